[rtl/csvt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_pkg
// Types and constants shared by the CSV row and field tokenizer modules.
// ----------------------------------------------------------------------------
package csvt_pkg;

    // fixed character codes
    localparam logic [7:0] LF_BYTE        = 8'd10;
    localparam logic [7:0] CR_BYTE        = 8'd13;
    localparam logic [7:0] DELIMITER_INIT = 8'd44;
    localparam logic [7:0] QUOTE_INIT     = 8'd34;
    localparam logic [7:0] ESCAPE_INIT    = 8'd92;

    // configuration register indexes
    localparam logic [1:0] REG_DELIMITER = 2'd0;
    localparam logic [1:0] REG_QUOTE     = 2'd1;
    localparam logic [1:0] REG_ESCAPE    = 2'd2;

    // column modes
    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_PLAIN   = 2'd1;
    localparam logic [1:0] MODE_QUOTED  = 2'd2;
    localparam logic [1:0] MODE_DISCARD = 2'd3;

    // most results one input byte can cause
    localparam int MAX_RES = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_out;
        logic       column_end;
        logic       row_end;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [7:0] delimiter_char;
        logic [7:0] quote_char;
        logic [7:0] escape_char;
    } cfg_t;

    // results of one input byte, item 0 goes out first
    typedef struct packed {
        out_t [MAX_RES-1:0] item;
        logic [1:0]         count;
    } bundle_t;

endpackage

[rtl/csv_row_and_field_tokenizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_row_and_field_tokenizer
// CSV text in, one byte per transfer; field bytes and column/row marks out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data): one text byte per transfer, or an
// end_of_input item that flushes the last row when it has no line feed.
// Output channel (out_valid/out_ready/out_data): each input byte gives zero to
// three results, sent one per transfer in order; last marks the final one.
// Config port (cfg_we/cfg_index/cfg_data): writes delimiter, quote and escape
// characters; write only while no results are pending.
// Latency: the first result of a byte is offered the cycle after its transfer.
// Throughput: one input byte per cycle while out_ready is high and each byte
// gives at most one result; a byte with more results holds the input, since
// the output register drains one result per transfer and the next byte is
// taken in the cycle its predecessor's last result transfers.
// Reset: parser state clears to column start with even quote count, the
// characters return to comma, double quote and backslash, no result pending.
// Stall: while out_ready is low the pending result holds and in_ready drops
// once no more room is left.
// ----------------------------------------------------------------------------
module csv_row_and_field_tokenizer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  csvt_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output csvt_pkg::out_t out_data,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [7:0]     cfg_data
);

    csvt_pkg::cfg_t    cfg;
    csvt_pkg::bundle_t results;
    logic              in_xfer;

    assign in_xfer = in_valid && in_ready;

    // character registers
    csvt_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // parser state and per-byte update
    csvt_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .in_data (in_data),
        .load    (in_xfer),
        .results (results)
    );

    // result register
    csvt_result_buf u_result_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .results   (results),
        .load      (in_xfer),
        .can_load  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[rtl/csvt_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_cfg_regs
// Delimiter, quote and escape character registers behind a plain write port.
// ----------------------------------------------------------------------------
module csvt_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [7:0]      cfg_data,
    output csvt_pkg::cfg_t  cfg
);

    csvt_pkg::cfg_t cfg_reg;
    csvt_pkg::cfg_t cfg_next;

    // decode the register write, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                csvt_pkg::REG_DELIMITER: cfg_next.delimiter_char = cfg_data;
                csvt_pkg::REG_QUOTE:     cfg_next.quote_char     = cfg_data;
                csvt_pkg::REG_ESCAPE:    cfg_next.escape_char    = cfg_data;
                default:                 cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delimiter_char <= csvt_pkg::DELIMITER_INIT;
            cfg_reg.quote_char     <= csvt_pkg::QUOTE_INIT;
            cfg_reg.escape_char    <= csvt_pkg::ESCAPE_INIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/csvt_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_step
// Parser state register and the per-byte update that forms up to three
// results for one input transfer.
// ----------------------------------------------------------------------------
module csvt_step (
    input  logic              clk,
    input  logic              rst_n,
    input  csvt_pkg::cfg_t    cfg,
    input  csvt_pkg::in_t     in_data,
    input  logic              load,
    output csvt_pkg::bundle_t results
);

    typedef struct packed {
        logic       quote_parity;
        logic [1:0] field_mode;
        logic       held_quote;
        logic       held_escape;
        logic       held_return;
        logic       row_has_bytes;
    } state_t;

    typedef struct packed {
        state_t            st;
        csvt_pkg::bundle_t res;
    } work_t;

    state_t state_reg;
    state_t state_next;

    function automatic state_t clear_state();
        state_t s;
        s.quote_parity  = 1'b0;
        s.field_mode    = csvt_pkg::MODE_START;
        s.held_quote    = 1'b0;
        s.held_escape   = 1'b0;
        s.held_return   = 1'b0;
        s.row_has_bytes = 1'b0;
        return s;
    endfunction

    function automatic csvt_pkg::bundle_t emit(csvt_pkg::bundle_t b, logic v,
                                               logic [7:0] ch, logic ce, logic re);
        csvt_pkg::out_t    r;
        csvt_pkg::bundle_t n;
        n            = b;
        r.char_valid = v;
        r.char_out   = ch;
        r.column_end = ce;
        r.row_end    = re;
        r.last       = 1'b0;
        if (b.count != 2'(csvt_pkg::MAX_RES))
        begin
            n.item[b.count] = r;
            n.count         = b.count + 2'd1;
        end
        return n;
    endfunction

    // byte that is neither a pending escape nor a pending quote start
    function automatic work_t plain_byte(work_t w, logic [7:0] x, csvt_pkg::cfg_t c);
        work_t n;
        logic  ends;
        n    = w;
        ends = (w.st.field_mode == csvt_pkg::MODE_QUOTED) ? (x == c.quote_char)
                                                          : (x == c.delimiter_char);
        if (ends)
        begin
            n.res = emit(n.res, 1'b0, 8'd0, 1'b1, 1'b0);
            n.st.field_mode = (w.st.field_mode == csvt_pkg::MODE_QUOTED)
                              ? csvt_pkg::MODE_DISCARD : csvt_pkg::MODE_START;
        end
        else
        begin
            n.res = emit(n.res, 1'b1, x, 1'b0, 1'b0);
        end
        return n;
    endfunction

    function automatic work_t content_byte(work_t w, logic [7:0] cb, csvt_pkg::cfg_t c);
        work_t n;
        logic  done;
        logic  skip;
        n    = w;
        done = 1'b0;
        skip = 1'b0;
        if (n.st.held_escape)
        begin
            n.st.held_escape = 1'b0;
            n = plain_byte(n, cb, c);
        end
        else
        begin
            // quote held from the previous byte: doubled quote or literal quote
            if (n.st.held_quote)
            begin
                n.st.held_quote = 1'b0;
                if (cb == c.quote_char)
                begin
                    done = 1'b1;
                    if (cb == c.delimiter_char)
                    begin
                        n.res = emit(n.res, 1'b0, 8'd0, 1'b1, 1'b0);
                        n.st.field_mode = csvt_pkg::MODE_START;
                    end
                    else
                    begin
                        n.res = emit(n.res, 1'b1, cb, 1'b0, 1'b0);
                    end
                end
                else
                begin
                    n = plain_byte(n, c.quote_char, c);
                end
            end
            if (!done)
            begin
                if (n.st.field_mode == csvt_pkg::MODE_DISCARD)
                begin
                    if (cb == c.delimiter_char)
                        n.st.field_mode = csvt_pkg::MODE_START;
                end
                else
                begin
                    // column start: an opening quote switches to quoted mode
                    if (n.st.field_mode == csvt_pkg::MODE_START)
                    begin
                        if (cb == c.quote_char)
                        begin
                            n.st.field_mode = csvt_pkg::MODE_QUOTED;
                            skip = 1'b1;
                        end
                        else
                        begin
                            n.st.field_mode = csvt_pkg::MODE_PLAIN;
                        end
                    end
                    if (!skip)
                    begin
                        if (cb == c.escape_char)
                            n.st.held_escape = 1'b1;
                        else if (cb == c.quote_char)
                            n.st.held_quote = 1'b1;
                        else
                            n = plain_byte(n, cb, c);
                    end
                end
            end
        end
        return n;
    endfunction

    // release held bytes, then the row mark
    function automatic work_t content_row_end(work_t w, csvt_pkg::cfg_t c);
        work_t n;
        logic  open;
        n = w;
        if (n.st.held_escape)
        begin
            n.st.held_escape = 1'b0;
            n = plain_byte(n, c.escape_char, c);
        end
        if (n.st.held_quote)
        begin
            n.st.held_quote = 1'b0;
            n = plain_byte(n, c.quote_char, c);
        end
        open = (n.st.field_mode == csvt_pkg::MODE_PLAIN) ||
               (n.st.field_mode == csvt_pkg::MODE_QUOTED);
        n.res = emit(n.res, 1'b0, 8'd0, open, 1'b1);
        n.st.field_mode = csvt_pkg::MODE_START;
        return n;
    endfunction

    // per-byte update
    always_comb
    begin
        work_t w;
        logic  term;
        w.st  = state_reg;
        w.res = '0;
        term  = 1'b0;
        if (in_data.end_of_input)
        begin
            if (w.st.held_return)
            begin
                w.st.held_return = 1'b0;
                w = content_byte(w, csvt_pkg::CR_BYTE, cfg);
            end
            if (w.st.row_has_bytes)
                w = content_row_end(w, cfg);
            w.st = clear_state();
        end
        else
        begin
            if (in_data.in_byte == cfg.quote_char)
                w.st.quote_parity = ~w.st.quote_parity;
            else if (in_data.in_byte == csvt_pkg::LF_BYTE && !w.st.quote_parity)
                term = 1'b1;

            if (term)
            begin
                w.st.held_return = 1'b0;
                w = content_row_end(w, cfg);
                w.st = clear_state();
            end
            else
            begin
                if (w.st.held_return)
                begin
                    w.st.held_return = 1'b0;
                    w = content_byte(w, csvt_pkg::CR_BYTE, cfg);
                end
                if (in_data.in_byte == csvt_pkg::CR_BYTE)
                    w.st.held_return = 1'b1;
                else
                    w = content_byte(w, in_data.in_byte, cfg);
                w.st.row_has_bytes = 1'b1;
            end
        end
        // flag the final result of this byte
        if (w.res.count != 2'd0)
            w.res.item[w.res.count - 2'd1].last = 1'b1;
        results    = w.res;
        state_next = w.st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= clear_state();
        else if (load)
            state_reg <= state_next;
    end

endmodule

[rtl/csvt_result_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_result_buf
// Result register for the results of one input byte, sent out one per
// transfer; takes the next group in the cycle the last one leaves.
// ----------------------------------------------------------------------------
module csvt_result_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  csvt_pkg::bundle_t results,
    input  logic              load,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output csvt_pkg::out_t    out_data
);

    csvt_pkg::out_t [csvt_pkg::MAX_RES-1:0] item_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [1:0] rd_reg;
    logic [1:0] rd_next;
    logic       out_xfer;

    assign out_valid = (rd_reg != cnt_reg);
    assign out_xfer  = out_valid && out_ready;
    assign out_data  = item_reg[rd_reg];

    // free now, or the final pending result leaves this cycle
    assign can_load = !out_valid || (out_xfer && (rd_reg + 2'd1 == cnt_reg));

    // read pointer and fill count
    always_comb
    begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (load)
        begin
            cnt_next = results.count;
            rd_next  = 2'd0;
        end
        else if (out_xfer)
        begin
            rd_next = rd_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= results.item;
    end

endmodule

[rtl/csvt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_checker
// Port-level checks for the CSV tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module csvt_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input csvt_pkg::out_t out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // input only stalls behind a pending result
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    // a result is a byte or a mark, never both
    a_byte_or_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.char_valid |-> !out_data.column_end && !out_data.row_end)
        else $error("field byte carries a mark");

    // marks carry a zero byte and at least one mark bit
    a_mark_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.char_valid |->
            out_data.char_out == 8'd0 && (out_data.column_end || out_data.row_end))
        else $error("malformed mark");

endmodule

bind csv_row_and_field_tokenizer csvt_checker u_csvt_checker (.*);
